// ===== src/pwb_pkg.sv =====
// ----------------------------------------------------------------------------
// pwb_pkg
// shared types, widths and constants of the pixel write blend unit
// ----------------------------------------------------------------------------
`default_nettype none

package pwb_pkg;

  localparam int COORD_W   = 13;
  localparam int DIM_W     = 13;
  localparam int PIX_W     = 32;
  localparam int CH_W      = 8;
  localparam int NUM_CH    = PIX_W / CH_W;
  localparam int ROW_W     = 2 * DIM_W;
  localparam int ADDR_W    = 24;
  localparam int MIX_W     = 2 * CH_W;
  localparam int CFG_IDX_W = 2;

  localparam int MAX_DIM_DEFAULT = 4096;

  localparam logic [DIM_W-1:0] RST_DEST_WIDTH  = 13'd640;
  localparam logic [DIM_W-1:0] RST_DEST_HEIGHT = 13'd480;
  localparam logic [DIM_W-1:0] RST_ROW_PITCH   = 13'd640;

  localparam logic [CH_W-1:0] CH_FULL = 8'hFF;

  // n / 255 == (n * RECIP_255) >> RECIP_SHIFT for every 16-bit n
  localparam logic [MIX_W-1:0] RECIP_255   = 16'h8081;
  localparam int               RECIP_SHIFT = 23;

  localparam logic [CFG_IDX_W-1:0] REG_DEST_WIDTH  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_DEST_HEIGHT = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_ROW_PITCH   = 2'd2;

  typedef struct packed {
    logic [DIM_W-1:0] dest_width;
    logic [DIM_W-1:0] dest_height;
    logic [DIM_W-1:0] row_pitch;
  } cfg_t;

  typedef struct packed {
    logic valid;
    logic ok;
    logic blend;
  } ctl_t;

endpackage

`default_nettype wire

// ===== src/pixel_write_blend_unit_top.sv =====
// ----------------------------------------------------------------------------
// pixel_write_blend_unit_top
// clipped, color-keyed pixel write with per-channel alpha blend
// ----------------------------------------------------------------------------
// busy is always low: a beat is taken on every cycle start is high, one per
// clock. Each beat gives exactly one result, shown for one cycle with
// out_valid; the receiver cannot stall, so it must take it then.
// The result passes through three register stages: qualification and row
// multiply, channel weighted sums and address add, reciprocal divide by 255.
// Dropped writes come out with write enable, address and data all zero.
// Configuration writes take effect from the next beat and belong to idle periods.
// ----------------------------------------------------------------------------
`default_nettype none

module pixel_write_blend_unit_top #(
  parameter int MAX_DIM = pwb_pkg::MAX_DIM_DEFAULT
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               start,
  output logic                               busy,
  input  logic signed [pwb_pkg::COORD_W-1:0] in_dest_x,
  input  logic signed [pwb_pkg::COORD_W-1:0] in_dest_y,
  input  logic [pwb_pkg::PIX_W-1:0]          in_dest_pixel,
  input  logic [pwb_pkg::PIX_W-1:0]          in_source_color,
  input  logic                               in_from_image,
  input  logic                               in_overlap_enable,
  input  logic [pwb_pkg::PIX_W-1:0]          in_overlap_color,
  input  logic                               in_blend_enable,
  input  logic [pwb_pkg::CH_W-1:0]           in_opacity,
  output logic                               out_valid,
  output logic                               out_write_enable,
  output logic [pwb_pkg::ADDR_W-1:0]         out_write_address,
  output logic [pwb_pkg::PIX_W-1:0]          out_write_data,
  input  logic                               cfg_write_enable,
  input  logic [pwb_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [pwb_pkg::DIM_W-1:0]          cfg_data
);

  pwb_pkg::cfg_t                  cfg;
  pwb_pkg::ctl_t                  s1_ctl;
  logic [pwb_pkg::CH_W-1:0]       s1_weight;
  logic [pwb_pkg::PIX_W-1:0]      s1_dst;
  logic [pwb_pkg::PIX_W-1:0]      s1_src;
  logic [pwb_pkg::ROW_W-1:0]      s1_row;
  logic [pwb_pkg::COORD_W-1:0]    s1_x;

  assign busy = 1'b0;

  pwb_cfg_regs #(
    .MAX_DIM (MAX_DIM)
  ) u_cfg (
    .clk              (clk),
    .rst_n            (rst_n),
    .cfg_write_enable (cfg_write_enable),
    .cfg_index        (cfg_index),
    .cfg_data         (cfg_data),
    .cfg              (cfg)
  );

  pwb_front u_front (
    .clk               (clk),
    .rst_n             (rst_n),
    .start             (start),
    .in_dest_x         (in_dest_x),
    .in_dest_y         (in_dest_y),
    .in_dest_pixel     (in_dest_pixel),
    .in_source_color   (in_source_color),
    .in_from_image     (in_from_image),
    .in_overlap_enable (in_overlap_enable),
    .in_overlap_color  (in_overlap_color),
    .in_blend_enable   (in_blend_enable),
    .in_opacity        (in_opacity),
    .cfg               (cfg),
    .s1_ctl            (s1_ctl),
    .s1_weight         (s1_weight),
    .s1_dst            (s1_dst),
    .s1_src            (s1_src),
    .s1_row            (s1_row),
    .s1_x              (s1_x)
  );

  pwb_mix u_mix (
    .clk               (clk),
    .rst_n             (rst_n),
    .s1_ctl            (s1_ctl),
    .s1_weight         (s1_weight),
    .s1_dst            (s1_dst),
    .s1_src            (s1_src),
    .s1_row            (s1_row),
    .s1_x              (s1_x),
    .out_valid         (out_valid),
    .out_write_enable  (out_write_enable),
    .out_write_address (out_write_address),
    .out_write_data    (out_write_data)
  );

endmodule

`default_nettype wire

// ===== src/pwb_cfg_regs.sv =====
// ----------------------------------------------------------------------------
// pwb_cfg_regs
// clip and pitch registers, written values saturate at the maximum dimension
// ----------------------------------------------------------------------------
`default_nettype none

module pwb_cfg_regs #(
  parameter int MAX_DIM = pwb_pkg::MAX_DIM_DEFAULT
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           cfg_write_enable,
  input  logic [pwb_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [pwb_pkg::DIM_W-1:0]      cfg_data,
  output pwb_pkg::cfg_t                  cfg
);

  pwb_pkg::cfg_t               cfg_r;
  pwb_pkg::cfg_t               cfg_nxt;
  logic [pwb_pkg::DIM_W-1:0]   clamped;

  always_comb begin
    if (32'(cfg_data) > MAX_DIM) begin
      clamped = pwb_pkg::DIM_W'(MAX_DIM);
    end else begin
      clamped = cfg_data;
    end
  end

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_write_enable) begin
      unique case (cfg_index)
        pwb_pkg::REG_DEST_WIDTH:  cfg_nxt.dest_width  = clamped;
        pwb_pkg::REG_DEST_HEIGHT: cfg_nxt.dest_height = clamped;
        pwb_pkg::REG_ROW_PITCH:   cfg_nxt.row_pitch   = clamped;
        default:                  cfg_nxt = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.dest_width  <= pwb_pkg::RST_DEST_WIDTH;
      cfg_r.dest_height <= pwb_pkg::RST_DEST_HEIGHT;
      cfg_r.row_pitch   <= pwb_pkg::RST_ROW_PITCH;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  assign cfg = cfg_r;

endmodule

`default_nettype wire

// ===== src/pwb_front.sv =====
// ----------------------------------------------------------------------------
// pwb_front
// first stage: clip, overlap and alpha qualification, blend weight, row offset
// ----------------------------------------------------------------------------
`default_nettype none

module pwb_front (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              start,
  input  logic signed [pwb_pkg::COORD_W-1:0] in_dest_x,
  input  logic signed [pwb_pkg::COORD_W-1:0] in_dest_y,
  input  logic [pwb_pkg::PIX_W-1:0]         in_dest_pixel,
  input  logic [pwb_pkg::PIX_W-1:0]         in_source_color,
  input  logic                              in_from_image,
  input  logic                              in_overlap_enable,
  input  logic [pwb_pkg::PIX_W-1:0]         in_overlap_color,
  input  logic                              in_blend_enable,
  input  logic [pwb_pkg::CH_W-1:0]          in_opacity,
  input  pwb_pkg::cfg_t                     cfg,
  output pwb_pkg::ctl_t                     s1_ctl,
  output logic [pwb_pkg::CH_W-1:0]          s1_weight,
  output logic [pwb_pkg::PIX_W-1:0]         s1_dst,
  output logic [pwb_pkg::PIX_W-1:0]         s1_src,
  output logic [pwb_pkg::ROW_W-1:0]         s1_row,
  output logic [pwb_pkg::COORD_W-1:0]       s1_x
);

  pwb_pkg::ctl_t                    ctl_r;
  pwb_pkg::ctl_t                    ctl_nxt;
  logic [pwb_pkg::CH_W-1:0]         weight_r;
  logic [pwb_pkg::CH_W-1:0]         weight_nxt;
  logic [pwb_pkg::PIX_W-1:0]        dst_r;
  logic [pwb_pkg::PIX_W-1:0]        src_r;
  logic [pwb_pkg::ROW_W-1:0]        row_r;
  logic [pwb_pkg::ROW_W-1:0]        row_nxt;
  logic [pwb_pkg::COORD_W-1:0]      x_r;
  logic [pwb_pkg::COORD_W-1:0]      x_u;
  logic [pwb_pkg::COORD_W-1:0]      y_u;
  logic [pwb_pkg::CH_W-1:0]         src_alpha;
  logic                             in_bounds;
  logic                             overlap_miss;
  logic                             opaque_skip;

  assign x_u       = $unsigned(in_dest_x);
  assign y_u       = $unsigned(in_dest_y);
  assign src_alpha = in_source_color[pwb_pkg::PIX_W-1 -: pwb_pkg::CH_W];

  assign in_bounds = !in_dest_x[pwb_pkg::COORD_W-1] && !in_dest_y[pwb_pkg::COORD_W-1]
                  && (x_u < cfg.dest_width) && (y_u < cfg.dest_height);
  assign overlap_miss = in_overlap_enable && (in_dest_pixel != in_overlap_color);
  assign opaque_skip  = in_from_image && (src_alpha == pwb_pkg::CH_FULL);

  always_comb begin
    ctl_nxt.valid = start;
    ctl_nxt.ok    = in_bounds && !overlap_miss && !opaque_skip;
    ctl_nxt.blend = in_blend_enable;
    if (in_opacity == '0) begin
      weight_nxt = pwb_pkg::CH_FULL - src_alpha;
    end else begin
      weight_nxt = in_opacity;
    end
    row_nxt = pwb_pkg::ROW_W'(y_u) * pwb_pkg::ROW_W'(cfg.row_pitch);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ctl_r <= '0;
    end else begin
      ctl_r <= ctl_nxt;
    end
  end

  always_ff @(posedge clk) begin
    weight_r <= weight_nxt;
    dst_r    <= in_dest_pixel;
    src_r    <= in_source_color;
    row_r    <= row_nxt;
    x_r      <= x_u;
  end

  assign s1_ctl    = ctl_r;
  assign s1_weight = weight_r;
  assign s1_dst    = dst_r;
  assign s1_src    = src_r;
  assign s1_row    = row_r;
  assign s1_x      = x_r;

endmodule

`default_nettype wire

// ===== src/pwb_mix.sv =====
// ----------------------------------------------------------------------------
// pwb_mix
// second and third stages: channel weighted sums and address add, then
// divide by 255 through a reciprocal multiply and result select
// ----------------------------------------------------------------------------
`default_nettype none

module pwb_mix (
  input  logic                          clk,
  input  logic                          rst_n,
  input  pwb_pkg::ctl_t                 s1_ctl,
  input  logic [pwb_pkg::CH_W-1:0]      s1_weight,
  input  logic [pwb_pkg::PIX_W-1:0]     s1_dst,
  input  logic [pwb_pkg::PIX_W-1:0]     s1_src,
  input  logic [pwb_pkg::ROW_W-1:0]     s1_row,
  input  logic [pwb_pkg::COORD_W-1:0]   s1_x,
  output logic                          out_valid,
  output logic                          out_write_enable,
  output logic [pwb_pkg::ADDR_W-1:0]    out_write_address,
  output logic [pwb_pkg::PIX_W-1:0]     out_write_data
);

  localparam int NCH  = pwb_pkg::NUM_CH;
  localparam int CW   = pwb_pkg::CH_W;
  localparam int MW   = pwb_pkg::MIX_W;
  localparam int QW   = 2 * MW;

  pwb_pkg::ctl_t                 ctl2_r;
  logic [MW-1:0]                 sum2_r [NCH];
  logic [MW-1:0]                 sum2_nxt [NCH];
  logic [pwb_pkg::PIX_W-1:0]     src2_r;
  logic [pwb_pkg::ADDR_W-1:0]    addr2_r;
  logic [pwb_pkg::ADDR_W-1:0]    addr2_nxt;
  logic [CW-1:0]                 inv_weight;

  logic                          valid3_r;
  logic                          we3_r;
  logic                          we3_nxt;
  logic [pwb_pkg::ADDR_W-1:0]    addr3_r;
  logic [pwb_pkg::ADDR_W-1:0]    addr3_nxt;
  logic [pwb_pkg::PIX_W-1:0]     data3_r;
  logic [pwb_pkg::PIX_W-1:0]     data3_nxt;
  logic [pwb_pkg::PIX_W-1:0]     blended;
  logic [QW-1:0]                 quot_full [NCH];

  // stage two
  assign inv_weight = pwb_pkg::CH_FULL - s1_weight;

  always_comb begin
    for (int c = 0; c < NCH; c++) begin
      sum2_nxt[c] = MW'(s1_dst[c*CW +: CW]) * MW'(inv_weight)
                  + MW'(s1_src[c*CW +: CW]) * MW'(s1_weight);
    end
    addr2_nxt = pwb_pkg::ADDR_W'(s1_row + pwb_pkg::ROW_W'(s1_x));
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ctl2_r <= '0;
    end else begin
      ctl2_r <= s1_ctl;
    end
  end

  always_ff @(posedge clk) begin
    sum2_r  <= sum2_nxt;
    src2_r  <= s1_src;
    addr2_r <= addr2_nxt;
  end

  // stage three
  always_comb begin
    for (int c = 0; c < NCH; c++) begin
      quot_full[c] = QW'(sum2_r[c]) * QW'(pwb_pkg::RECIP_255);
      blended[c*CW +: CW] = quot_full[c][pwb_pkg::RECIP_SHIFT +: CW];
    end
    we3_nxt = ctl2_r.valid && ctl2_r.ok;
    if (ctl2_r.ok) begin
      addr3_nxt = addr2_r;
      data3_nxt = ctl2_r.blend ? blended : src2_r;
    end else begin
      addr3_nxt = '0;
      data3_nxt = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid3_r <= 1'b0;
      we3_r    <= 1'b0;
    end else begin
      valid3_r <= ctl2_r.valid;
      we3_r    <= we3_nxt;
    end
  end

  always_ff @(posedge clk) begin
    addr3_r <= addr3_nxt;
    data3_r <= data3_nxt;
  end

  assign out_valid         = valid3_r;
  assign out_write_enable  = we3_r;
  assign out_write_address = addr3_r;
  assign out_write_data    = data3_r;

endmodule

`default_nettype wire
